// ----- sv/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

  // Counter and register widths
  localparam int COUNT_BITS   = 18;
  localparam int TRIG_BITS    = 8;
  localparam int TIMEOUT_BITS = 18;
  localparam int CMP_BITS     = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;
  localparam int CFG_DATA_BITS = TIMEOUT_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // Measured echo width fits in the timeout counter width
  localparam int WIDTH_BITS = TIMEOUT_BITS;
  localparam int DIST_BITS  = 10;
  localparam int DIGIT_BITS = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT_TICKS = 2'd1;

  localparam logic [TRIG_BITS-1:0]    TRIGGER_RESET = 8'd42;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 18'd131072;

  // Phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_MEAS = 2'd3;

  // distance = floor(w*34/10000) = (w * 34*ceil(2^38/10000)) >> 38, exact for 34*w < 2^24
  localparam int DIST_MUL_BITS = 30;
  localparam logic [DIST_MUL_BITS-1:0] DIST_MUL = 30'd934584894;
  localparam int DIST_SHIFT = 38;
  localparam int DIST_PROD_BITS = WIDTH_BITS + DIST_MUL_BITS;

  // Digit split: d/100 = (d*41)>>12 for d < 1000, r/10 = (r*103)>>10 for r < 100
  localparam logic [5:0] HUND_MUL   = 6'd41;
  localparam int         HUND_SHIFT = 12;
  localparam logic [6:0] TENS_MUL   = 7'd103;
  localparam int         TENS_SHIFT = 10;

  typedef struct packed {
    logic [TRIG_BITS-1:0]    trigger_ticks;
    logic [TIMEOUT_BITS-1:0] timeout_ticks;
  } cfg_t;

  // Result of the sequencer stage
  typedef struct packed {
    logic                  trig;
    logic                  done;
    logic                  tmo;
    logic [WIDTH_BITS-1:0] width;
  } seq_res_t;

  // Result of the distance stage
  typedef struct packed {
    logic                 trig;
    logic                 done;
    logic                 tmo;
    logic [DIST_BITS-1:0] dist_val;
  } dist_res_t;

endpackage

// ----- sv/uer_ctrl.sv -----
// Ranging sequencer: trigger, echo wait and echo measure phases with timeouts.
// Depends on uer_pkg; feeds uer_dist.
module uer_ctrl import uer_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     start_req,
  input  logic     echo,
  output logic     res_valid,
  input  logic     res_ready,
  output seq_res_t res
);

  logic [1:0]            phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, count_next;
  logic [COUNT_BITS-1:0] bumped;
  logic                  trig_end, limit_hit, accept, ready;
  seq_res_t              res_next;

  assign ready    = !res_valid || res_ready;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // Saturating count and phase-end compares
  assign bumped    = (tick_count == COUNT_MAX) ? tick_count : tick_count + 1'b1;
  assign trig_end  = (CMP_BITS'(bumped) >= CMP_BITS'(cfg.trigger_ticks)) ||
                     (bumped == COUNT_MAX);
  assign limit_hit = (CMP_BITS'(bumped) >= CMP_BITS'(cfg.timeout_ticks)) ||
                     (bumped == COUNT_MAX);

  // Next phase and result for one tick
  always_comb begin
    phase_next = phase;
    count_next = tick_count;
    res_next   = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          res_next.trig = 1'b1;
          if (cfg.trigger_ticks <= TRIG_BITS'(1)) begin
            phase_next = PH_WAIT;
            count_next = '0;
          end else begin
            phase_next = PH_TRIG;
            count_next = COUNT_BITS'(1);
          end
        end
      end
      PH_TRIG: begin
        res_next.trig = 1'b1;
        count_next    = bumped;
        if (trig_end) begin
          phase_next = PH_WAIT;
          count_next = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_next = PH_MEAS;
          count_next = COUNT_BITS'(1);
        end else begin
          count_next = bumped;
          if (limit_hit) begin
            res_next.done = 1'b1;
            res_next.tmo  = 1'b1;
            phase_next    = PH_IDLE;
            count_next    = '0;
          end
        end
      end
      PH_MEAS: begin
        if (!echo) begin
          res_next.done  = 1'b1;
          res_next.width = WIDTH_BITS'(tick_count);
          phase_next     = PH_IDLE;
          count_next     = '0;
        end else begin
          count_next = bumped;
          if (limit_hit) begin
            res_next.done = 1'b1;
            res_next.tmo  = 1'b1;
            phase_next    = PH_IDLE;
            count_next    = '0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // State and stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        tick_count <= count_next;
      end
      if (ready) begin
        res_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // A finished measurement always leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done |-> phase == PH_IDLE)
    else $error("done result while sequencer busy");

  a_tmo_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.tmo |-> res.done && res.width == '0)
    else $error("timeout without done or with nonzero width");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_IDLE && !start_req |=> phase == PH_IDLE)
    else $error("left idle without a start request");

endmodule

// ----- sv/uer_dist.sv -----
// Distance stage: echo width times 34/10000 by one reciprocal multiply.
// Depends on uer_pkg; sits between uer_ctrl and uer_digits.
module uer_dist import uer_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  seq_res_t  in_res,
  output logic      res_valid,
  input  logic      res_ready,
  output dist_res_t res
);

  logic [DIST_PROD_BITS-1:0] prod;
  dist_res_t                 res_next;

  assign in_ready = !res_valid || res_ready;

  // Reciprocal multiply; width is zero on timeout and idle ticks
  assign prod = DIST_PROD_BITS'(in_res.width) * DIST_PROD_BITS'(DIST_MUL);

  always_comb begin
    res_next.trig     = in_res.trig;
    res_next.done     = in_res.done;
    res_next.tmo      = in_res.tmo;
    res_next.dist_val = prod[DIST_SHIFT +: DIST_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_ready) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res <= res_next;
    end
  end

  a_tmo_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.tmo || !res.done) |-> res.dist_val == '0)
    else $error("nonzero distance without a good measurement");

endmodule

// ----- sv/uer_digits.sv -----
// Output stage: splits distance into decimal digits and holds the result register.
// Depends on uer_pkg; fed by uer_dist.
module uer_digits import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dist_res_t             in_res,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  trig_level,
  output logic                  done_res,
  output logic                  timed_out,
  output logic [DIST_BITS-1:0]  distance,
  output logic [DIGIT_BITS-1:0] digit_hundreds,
  output logic [DIGIT_BITS-1:0] digit_tens,
  output logic [DIGIT_BITS-1:0] digit_units
);

  logic [15:0]           hund_prod;
  logic [DIGIT_BITS-1:0] hund;
  logic [DIST_BITS-1:0]  hund_rest;
  logic [6:0]            rem;
  logic [13:0]           tens_prod;
  logic [DIGIT_BITS-1:0] tens;
  logic [6:0]            unit_rest;

  assign in_ready = !out_valid || !out_stall;

  // Distance never exceeds 891, so the hundreds digit is d/100
  assign hund_prod = 16'(in_res.dist_val) * 16'(HUND_MUL);
  assign hund      = hund_prod[HUND_SHIFT +: DIGIT_BITS];
  assign hund_rest = in_res.dist_val - DIST_BITS'(hund) * DIST_BITS'(100);
  assign rem       = hund_rest[6:0];
  assign tens_prod = 14'(rem) * 14'(TENS_MUL);
  assign tens      = tens_prod[TENS_SHIFT +: DIGIT_BITS];
  assign unit_rest = rem - 7'(tens) * 7'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      trig_level     <= in_res.trig;
      done_res       <= in_res.done;
      timed_out      <= in_res.tmo;
      distance       <= in_res.dist_val;
      digit_hundreds <= hund;
      digit_tens     <= tens;
      digit_units    <= unit_rest[DIGIT_BITS-1:0];
    end
  end

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> !timed_out && distance == '0 &&
      digit_hundreds == '0 && digit_tens == '0 && digit_units == '0)
    else $error("result fields set on a tick without done");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_tens <= 4'd9 && digit_units <= 4'd9)
    else $error("decimal digit out of range");

endmodule

// ----- sv/ultrasonic_echo_ranger_top.sv -----
// Top level of the ultrasonic echo ranger: config registers and three-stage pipeline.
// Depends on uer_pkg, uer_ctrl, uer_dist and uer_digits.
//
//   port group   dir  handshake            payload
//   tick in      in   in_valid/in_stall    start_req, echo
//   result out   out  out_valid/out_stall  trig_level, done_res, timed_out,
//                                          distance, digit_hundreds/tens/units
//   config       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick request is taken every cycle unless in_stall is high; its result passes
// through the sequencer register, distance multiply register and digit/output register.
// The sequencer state advances only on accepted ticks, so stalls only delay.
// out_stall back-pressures the stages in place; in_stall rises only when all
// three stages hold data. Synchronous reset returns to idle with default config.
module ultrasonic_echo_ranger_top import uer_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      start_req,
  input  logic                      echo,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      trig_level,
  output logic                      done_res,
  output logic                      timed_out,
  output logic [DIST_BITS-1:0]      distance,
  output logic [DIGIT_BITS-1:0]     digit_hundreds,
  output logic [DIGIT_BITS-1:0]     digit_tens,
  output logic [DIGIT_BITS-1:0]     digit_units
);

  cfg_t      cfg;
  seq_res_t  seq_res;
  dist_res_t dist_res;
  logic      seq_valid, seq_ready, dist_valid, dist_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks <= TRIGGER_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TRIGGER_TICKS) begin
        cfg.trigger_ticks <= cfg_data[TRIG_BITS-1:0];
      end
      if (cfg_index == REG_TIMEOUT_TICKS) begin
        cfg.timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
      end
    end
  end

  uer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (start_req),
    .echo      (echo),
    .res_valid (seq_valid),
    .res_ready (seq_ready),
    .res       (seq_res)
  );

  uer_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .in_res    (seq_res),
    .res_valid (dist_valid),
    .res_ready (dist_ready),
    .res       (dist_res)
  );

  uer_digits u_digits (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (dist_valid),
    .in_ready       (dist_ready),
    .in_res         (dist_res),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trig_level     (trig_level),
    .done_res       (done_res),
    .timed_out      (timed_out),
    .distance       (distance),
    .digit_hundreds (digit_hundreds),
    .digit_tens     (digit_tens),
    .digit_units    (digit_units)
  );

endmodule
